// ----- hw/rtl/u8u2_pkg.sv -----
// Shared types and constants for the UTF-8 to UCS-2 decoder.
package u8u2_pkg;

  localparam int UNIT_W  = 16;
  localparam int LEFT_W  = 3;
  localparam logic [UNIT_W-1:0] MAX_UNITS_RESET = 16'd256;

  // Continuation byte tag in the top two bits.
  localparam logic [1:0] CONT_TAG = 2'b10;

  // Payload masks of the lead byte, by sequence length.
  localparam logic [7:0] LEAD2_MASK = 8'h1F;
  localparam logic [7:0] LEAD3_MASK = 8'h0F;
  localparam logic [7:0] LEAD4_MASK = 8'h07;
  localparam logic [7:0] LEAD5_MASK = 8'h03;
  localparam logic [7:0] LEAD6_MASK = 8'h01;
  localparam logic [7:0] CONT_MASK  = 8'h3F;

  typedef struct packed {
    logic [LEFT_W-1:0] bytes_left;
    logic [UNIT_W-1:0] point_accum;
    logic              seq_bad;
    logic [UNIT_W-1:0] units_done;
    logic              string_over;
  } dec_state_t;

  typedef struct packed {
    logic [UNIT_W-1:0] code_unit;
    logic              unit_valid;
    logic              bad_sequence;
    logic              end_of_string;
    logic [UNIT_W-1:0] unit_total;
  } dec_result_t;

endpackage

// ----- hw/rtl/u8u2_step.sv -----
// Per-byte decode: next string state and the result, if any, for one byte.
module u8u2_step import u8u2_pkg::*; (
  input  dec_state_t        cur,
  input  logic [7:0]        data_byte,
  input  logic              last_byte,
  input  logic [UNIT_W-1:0] max_units,
  output dec_state_t        nxt,
  output logic              has_res,
  output dec_result_t       res
);

  logic              emit_req;
  logic [UNIT_W-1:0] emit_code;
  logic              emit_bad;
  logic              bad_n;
  logic [UNIT_W-1:0] acc_n;
  logic [LEFT_W-1:0] left_n;
  logic [UNIT_W-1:0] units_inc;
  logic              unit_end;

  assign bad_n     = cur.seq_bad | (data_byte[7:6] != CONT_TAG);
  assign acc_n     = {cur.point_accum[UNIT_W-7:0], data_byte[5:0] & CONT_MASK[5:0]};
  assign left_n    = cur.bytes_left - LEFT_W'(1);
  assign units_inc = cur.units_done + UNIT_W'(1);
  assign unit_end  = last_byte || (units_inc == max_units);

  always_comb begin
    nxt       = cur;
    has_res   = 1'b0;
    res       = '0;
    emit_req  = 1'b0;
    emit_code = '0;
    emit_bad  = 1'b0;

    if (cur.string_over) begin
      // drop until the marked last byte, then re-arm
      if (last_byte) begin
        nxt = '0;
      end
    end else if (cur.bytes_left != '0) begin
      nxt.point_accum = acc_n;
      nxt.bytes_left  = left_n;
      nxt.seq_bad     = bad_n;
      if (left_n == '0) begin
        nxt.seq_bad = 1'b0;
        emit_req    = 1'b1;
        emit_code   = acc_n;
        emit_bad    = bad_n;
      end else if (last_byte) begin
        // sequence cut short
        nxt.bytes_left = '0;
        nxt.seq_bad    = 1'b0;
        emit_req       = 1'b1;
        emit_bad       = 1'b1;
      end
    end else if (!data_byte[7]) begin
      emit_req  = 1'b1;
      emit_code = {8'h00, data_byte};
    end else if (!data_byte[6]) begin
      // stray continuation in lead position ends the string
      has_res           = 1'b1;
      res.end_of_string = 1'b1;
      res.unit_total    = cur.units_done;
      if (last_byte) begin
        nxt = '0;
      end else begin
        nxt.string_over = 1'b1;
      end
    end else if (last_byte) begin
      nxt.seq_bad = 1'b0;
      emit_req    = 1'b1;
      emit_bad    = 1'b1;
    end else begin
      nxt.seq_bad = 1'b0;
      if (!data_byte[5]) begin
        nxt.bytes_left  = LEFT_W'(1);
        nxt.point_accum = {8'h00, data_byte & LEAD2_MASK};
      end else if (!data_byte[4]) begin
        nxt.bytes_left  = LEFT_W'(2);
        nxt.point_accum = {8'h00, data_byte & LEAD3_MASK};
      end else if (!data_byte[3]) begin
        nxt.bytes_left  = LEFT_W'(3);
        nxt.point_accum = {8'h00, data_byte & LEAD4_MASK};
      end else if (!data_byte[2]) begin
        nxt.bytes_left  = LEFT_W'(4);
        nxt.point_accum = {8'h00, data_byte & LEAD5_MASK};
      end else begin
        nxt.bytes_left  = LEFT_W'(5);
        nxt.point_accum = {8'h00, data_byte & LEAD6_MASK};
      end
    end

    if (emit_req) begin
      has_res = 1'b1;
      if (cur.units_done >= max_units) begin
        // no room left: end the string without a code unit
        res.end_of_string = 1'b1;
        res.unit_total    = cur.units_done;
        if (last_byte) begin
          nxt = '0;
        end else begin
          nxt.string_over = 1'b1;
        end
      end else begin
        nxt.units_done    = units_inc;
        res.code_unit     = emit_bad ? '0 : emit_code;
        res.unit_valid    = 1'b1;
        res.bad_sequence  = emit_bad;
        res.end_of_string = unit_end;
        res.unit_total    = units_inc;
        if (unit_end) begin
          if (last_byte) begin
            nxt = '0;
          end else begin
            nxt.string_over = 1'b1;
          end
        end
      end
    end
  end

endmodule

// ----- hw/rtl/u8u2_out_reg.sv -----
// Output register stage: holds one result word until the sink takes it.
module u8u2_out_reg import u8u2_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        load,
  input  dec_result_t load_res,
  output logic        space,
  output logic        out_valid,
  input  logic        out_ready,
  output dec_result_t held
);

  // take a new word when empty or when the held word leaves this cycle
  assign space = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (space) begin
      out_valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (space && load) begin
      held <= load_res;
    end
  end

endmodule

// ----- hw/rtl/utf8_to_ucs2_decoder.sv -----
// Top level of the UTF-8 to UCS-2 decoder.
// Takes one UTF-8 byte per cycle and gives at most one 16-bit code unit word per
// byte, in the cycle after the byte is accepted. The decode of a byte is a single
// pass through the step logic into the output register, so the sustained rate is
// one byte per clock; in_ready drops only while the output register holds a word
// that the sink has not taken. max_units may be written only while the block is
// idle; there is no reset sweep.
module utf8_to_ucs2_decoder import u8u2_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              max_units_we,
  input  logic [UNIT_W-1:0] max_units_wdata,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [7:0]        data_byte,
  input  logic              last_byte,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [UNIT_W-1:0] code_unit,
  output logic              unit_valid,
  output logic              bad_sequence,
  output logic              end_of_string,
  output logic [UNIT_W-1:0] unit_total
);

  logic [UNIT_W-1:0] max_units;
  dec_state_t        state;
  dec_state_t        state_next;
  logic              has_res;
  dec_result_t       res;
  dec_result_t       held;
  logic              space;
  logic              accept;

  assign in_ready = space;
  assign accept   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_units <= MAX_UNITS_RESET;
    end else if (max_units_we) begin
      max_units <= max_units_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (accept) begin
      state <= state_next;
    end
  end

  u8u2_step u_step (
    .cur       (state),
    .data_byte (data_byte),
    .last_byte (last_byte),
    .max_units (max_units),
    .nxt       (state_next),
    .has_res   (has_res),
    .res       (res)
  );

  u8u2_out_reg u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (accept && has_res),
    .load_res  (res),
    .space     (space),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .held      (held)
  );

  assign code_unit     = held.code_unit;
  assign unit_valid    = held.unit_valid;
  assign bad_sequence  = held.bad_sequence;
  assign end_of_string = held.end_of_string;
  assign unit_total    = held.unit_total;

endmodule

// ----- bench/utf8_to_ucs2_decoder_tb.sv -----
// Self-checking testbench for the UTF-8 to UCS-2 decoder: directed table, random strings.
`timescale 1ns / 1ps

module utf8_to_ucs2_decoder_tb import u8u2_pkg::*;;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int LONG_HOLD      = 80;
  localparam int SETTLE_CYCLES  = 4;
  localparam int PHASE_ITEMS    = 50;
  localparam int NUM_PHASES     = 8;

  typedef struct packed {
    logic [7:0]  b;
    logic        last;
    logic        typed;
    dec_result_t want;
  } stim_row_t;

  // Rows with a typed word are checked against it; the rest against the predictor.
  localparam stim_row_t DIRECTED [26] = '{
    '{8'h00, 1'b0, 1'b1, '{16'h0000, 1'b1, 1'b0, 1'b0, 16'd1}},
    '{8'h7F, 1'b0, 1'b1, '{16'h007F, 1'b1, 1'b0, 1'b0, 16'd2}},
    '{8'hC3, 1'b0, 1'b0, '0},
    '{8'hA9, 1'b0, 1'b1, '{16'h00E9, 1'b1, 1'b0, 1'b0, 16'd3}},
    '{8'hE2, 1'b0, 1'b0, '0},
    '{8'h82, 1'b0, 1'b0, '0},
    '{8'hAC, 1'b0, 1'b0, '0},
    '{8'hF8, 1'b0, 1'b0, '0},
    '{8'h88, 1'b0, 1'b0, '0},
    '{8'h80, 1'b0, 1'b0, '0},
    '{8'h80, 1'b0, 1'b0, '0},
    '{8'h80, 1'b0, 1'b0, '0},
    '{8'hFD, 1'b0, 1'b0, '0},
    '{8'hBF, 1'b0, 1'b0, '0},
    '{8'hBF, 1'b0, 1'b0, '0},
    '{8'hBF, 1'b0, 1'b0, '0},
    '{8'hBF, 1'b0, 1'b0, '0},
    '{8'hBF, 1'b0, 1'b0, '0},
    // bad continuation inside a three byte sequence
    '{8'hE2, 1'b0, 1'b0, '0},
    '{8'h41, 1'b0, 1'b0, '0},
    '{8'h82, 1'b0, 1'b1, '{16'h0000, 1'b1, 1'b1, 1'b0, 16'd7}},
    // sequence cut short by the last byte
    '{8'hE2, 1'b0, 1'b0, '0},
    '{8'h82, 1'b1, 1'b1, '{16'h0000, 1'b1, 1'b1, 1'b1, 16'd8}},
    // stray continuation in lead position, then drop up to the last byte
    '{8'h80, 1'b0, 1'b1, '{16'h0000, 1'b0, 1'b0, 1'b1, 16'd0}},
    '{8'hFF, 1'b1, 1'b0, '0},
    // lead byte that is also the last byte
    '{8'hC2, 1'b1, 1'b1, '{16'h0000, 1'b1, 1'b1, 1'b1, 16'd1}}
  };

  logic              clk = 1'b0;
  logic              rst;
  logic              max_units_we;
  logic [UNIT_W-1:0] max_units_wdata;
  logic              in_valid;
  logic              in_ready;
  logic [7:0]        data_byte;
  logic              last_byte;
  logic              out_valid;
  logic              out_ready;
  logic [UNIT_W-1:0] code_unit;
  logic              unit_valid;
  logic              bad_sequence;
  logic              end_of_string;
  logic [UNIT_W-1:0] unit_total;

  utf8_to_ucs2_decoder dut (
    .clk             (clk),
    .rst             (rst),
    .max_units_we    (max_units_we),
    .max_units_wdata (max_units_wdata),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .data_byte       (data_byte),
    .last_byte       (last_byte),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .code_unit       (code_unit),
    .unit_valid      (unit_valid),
    .bad_sequence    (bad_sequence),
    .end_of_string   (end_of_string),
    .unit_total      (unit_total)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Decoder state as the predictor sees it.
  logic [LEFT_W-1:0] cont_left;
  logic [UNIT_W-1:0] point_bits;
  bit                cont_err;
  logic [UNIT_W-1:0] units_written;
  bit                dropping;
  logic [UNIT_W-1:0] unit_cap;

  dec_result_t       expected_units[$];
  logic [8:0]        string_bytes[$];   // {last, byte}
  dec_result_t       oldest_unit;
  int                err_count    = 0;
  int                stall_cycles = 0;
  bit                idle_on      = 1'b1;
  bit                hold_req     = 1'b0;

  task automatic report(input string msg);
    err_count++;
    $display("ERROR @%0t: %s", $realtime, msg);
  endtask

  task automatic check_field(input string name, input logic [15:0] got, input logic [15:0] want);
    if (got !== want)
      report($sformatf("%s got 0x%0h want 0x%0h", name, got, want));
  endtask

  function automatic void clear_string();
    cont_left     = '0;
    point_bits    = '0;
    cont_err      = 1'b0;
    units_written = '0;
    dropping      = 1'b0;
  endfunction

  function automatic void close_string(input bit last);
    if (last)
      clear_string();
    else
      dropping = 1'b1;
  endfunction

  // Write one unit, or end the string when the buffer has no room left.
  function automatic dec_result_t write_unit(input logic [UNIT_W-1:0] code, input bit bad,
                                             input bit last);
    dec_result_t r;
    bit          fin;
    r = '0;
    if (units_written >= unit_cap) begin
      r.end_of_string = 1'b1;
      r.unit_total    = units_written;
      close_string(last);
      return r;
    end
    units_written   = units_written + 1'b1;
    fin             = last || units_written == unit_cap;
    r.code_unit     = bad ? '0 : code;
    r.unit_valid    = 1'b1;
    r.bad_sequence  = bad;
    r.end_of_string = fin;
    r.unit_total    = units_written;
    if (fin)
      close_string(last);
    return r;
  endfunction

  function automatic bit decode_byte(input logic [7:0] b, input bit last, output dec_result_t r);
    bit          err_now;
    logic [7:0]  lead_bits;
    logic [2:0]  seq_len;
    r = '0;
    if (dropping) begin
      if (last)
        clear_string();
      return 1'b0;
    end
    if (cont_left != 0) begin
      if (b[7:6] != CONT_TAG)
        cont_err = 1'b1;
      point_bits = (point_bits << 6) | {8'h00, b & CONT_MASK};
      cont_left  = cont_left - 1'b1;
      if (cont_left == 0) begin
        err_now  = cont_err;
        cont_err = 1'b0;
        r = write_unit(point_bits, err_now, last);
        return 1'b1;
      end
      if (last) begin
        cont_left = '0;
        cont_err  = 1'b0;
        r = write_unit('0, 1'b1, 1'b1);
        return 1'b1;
      end
      return 1'b0;
    end
    if (b < 8'h80) begin
      r = write_unit({8'h00, b}, 1'b0, last);
      return 1'b1;
    end
    if (b < 8'hC0) begin
      r.end_of_string = 1'b1;
      r.unit_total    = units_written;
      close_string(last);
      return 1'b1;
    end
    if (b < 8'hE0) begin
      seq_len = 3'd2; lead_bits = b & LEAD2_MASK;
    end else if (b < 8'hF0) begin
      seq_len = 3'd3; lead_bits = b & LEAD3_MASK;
    end else if (b < 8'hF8) begin
      seq_len = 3'd4; lead_bits = b & LEAD4_MASK;
    end else if (b < 8'hFC) begin
      seq_len = 3'd5; lead_bits = b & LEAD5_MASK;
    end else begin
      seq_len = 3'd6; lead_bits = b & LEAD6_MASK;
    end
    if (last) begin
      cont_err = 1'b0;
      r = write_unit('0, 1'b1, 1'b1);
      return 1'b1;
    end
    cont_left  = seq_len - 1'b1;
    point_bits = {8'h00, lead_bits};
    cont_err   = 1'b0;
    return 1'b0;
  endfunction

  task automatic send_byte(input logic [7:0] b, input bit last, input bit typed,
                           input dec_result_t want);
    dec_result_t got;
    bit          has;
    @(negedge clk);
    if (idle_on && $urandom_range(0, 7) == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 17)) @(negedge clk);
    end
    in_valid  = 1'b1;
    data_byte = b;
    last_byte = last;
    do @(posedge clk); while (!in_ready);
    has = decode_byte(b, last, got);
    if (typed)
      expected_units.push_back(want);
    else if (has)
      expected_units.push_back(got);
  endtask

  // Drain the block, then write the buffer size.
  task automatic set_cap(input logic [UNIT_W-1:0] value);
    @(negedge clk);
    in_valid = 1'b0;
    while (expected_units.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
    max_units_we    = 1'b1;
    max_units_wdata = value;
    @(negedge clk);
    max_units_we = 1'b0;
    unit_cap     = value;
  endtask

  task automatic push_char(input int len, input int n_cont);
    logic [7:0] lead;
    logic [7:0] cont;
    lead = 8'($urandom);
    case (len)
      2:       lead[7:5] = 3'b110;
      3:       lead[7:4] = 4'b1110;
      4:       lead[7:3] = 5'b11110;
      5:       lead[7:2] = 6'b111110;
      default: lead[7:1] = 7'b1111110;
    endcase
    string_bytes.push_back({1'b0, lead});
    for (int k = 0; k < n_cont; k++) begin
      cont = 8'($urandom);
      if ($urandom_range(0, 24) != 0)
        cont[7:6] = CONT_TAG;
      string_bytes.push_back({1'b0, cont});
    end
  endtask

  // Mostly well-formed strings; some stray, noisy, bad or cut-short pieces.
  task automatic make_string();
    int         nchar;
    int         len;
    logic [8:0] w;
    nchar = $urandom_range(0, 10);
    for (int i = 0; i < nchar; i++) begin
      case ($urandom_range(0, 19))
        0:             string_bytes.push_back({1'b0, 2'b10, 6'($urandom)});
        1:             string_bytes.push_back({1'b0, 8'($urandom)});
        2, 3, 4, 5, 6,
        7, 8, 9:       string_bytes.push_back({1'b0, 1'b0, 7'($urandom)});
        default: begin
          len = $urandom_range(2, 6);
          push_char(len, len - 1);
        end
      endcase
    end
    if ($urandom_range(0, 5) == 0) begin
      len = $urandom_range(2, 6);
      push_char(len, $urandom_range(0, len - 2));
    end
    if (string_bytes.size() == 0) begin
      string_bytes.push_back({1'b1, 8'($urandom)});
    end else begin
      w    = string_bytes.pop_back();
      w[8] = 1'b1;
      string_bytes.push_back(w);
    end
  endtask

  // Count every byte sent, dropped ones included.
  task automatic run_random(input int num_items);
    int         sent;
    logic [8:0] w;
    sent = 0;
    while (sent < num_items) begin
      if (string_bytes.size() == 0)
        make_string();
      w = string_bytes.pop_front();
      sent++;
      send_byte(w[7:0], w[8], 1'b0, '0);
    end
  endtask

  // Sink side: random stalls, plus one long hold-off on request.
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_ready = 1'b0;
        repeat (LONG_HOLD - 1) @(negedge clk);
        hold_req = 1'b0;
      end else if (idle_on && $urandom_range(0, 9) == 0) begin
        out_ready = 1'b0;
        repeat ($urandom_range(1, 17) - 1) @(negedge clk);
      end else begin
        out_ready = 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (expected_units.size() == 0) begin
        report($sformatf("unexpected word code_unit 0x%0h", code_unit));
      end else begin
        oldest_unit = expected_units.pop_front();
        check_field("code_unit", code_unit, oldest_unit.code_unit);
        check_field("unit_valid", 16'(unit_valid), 16'(oldest_unit.unit_valid));
        check_field("bad_sequence", 16'(bad_sequence), 16'(oldest_unit.bad_sequence));
        check_field("end_of_string", 16'(end_of_string), 16'(oldest_unit.end_of_string));
        check_field("unit_total", unit_total, oldest_unit.unit_total);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("utf8_to_ucs2_decoder_tb failed");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    logic [UNIT_W-1:0] caps [NUM_PHASES];
    caps = '{16'd1, 16'd0, 16'd3, 16'd65535, 16'd2, 16'd4, 16'd5, 16'd256};
    caps[5] = UNIT_W'($urandom_range(1, 8));
    rst             = 1'b1;
    in_valid        = 1'b0;
    data_byte       = '0;
    last_byte       = 1'b0;
    max_units_we    = 1'b0;
    max_units_wdata = '0;
    unit_cap        = MAX_UNITS_RESET;
    clear_string();
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (DIRECTED[i])
      send_byte(DIRECTED[i].b, DIRECTED[i].last, DIRECTED[i].typed, DIRECTED[i].want);

    for (int p = 0; p < NUM_PHASES; p++) begin
      set_cap(caps[p]);
      if (p == 2)
        hold_req = 1'b1;
      if (p == NUM_PHASES - 1)
        idle_on = 1'b0;
      run_random(PHASE_ITEMS);
    end

    @(negedge clk);
    in_valid = 1'b0;
    while (expected_units.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES * 2) @(posedge clk);
    if (err_count == 0)
      $display("utf8_to_ucs2_decoder_tb passed");
    else
      $display("utf8_to_ucs2_decoder_tb failed");
    $finish;
  end

endmodule
